// ===== rtl/substring_matcher_case_fold_top_assert.svh =====
// Assertion macros shared by the matcher RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef SUBSTRING_MATCHER_CASE_FOLD_TOP_ASSERT_SVH
`define SUBSTRING_MATCHER_CASE_FOLD_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge while reset is released.
`define SCFC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define SCFC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SCFC_ASSERT(label, clk, rstn, prop, msg)
`define SCFC_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== rtl/scfc_pkg.sv =====
`default_nettype none

package scfc_pkg;

    localparam int NEEDLE_MAX     = 32;
    localparam int OFFSET_BITS    = 16;
    localparam int POS_BITS       = OFFSET_BITS + 1;
    localparam int LEN_BITS       = 6;
    localparam int NIDX_BITS      = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
    localparam int NEEDLE_WORDS   = 4;
    localparam int BYTES_PER_WORD = 8;
    localparam int NEEDLE_BYTES   = NEEDLE_WORDS * BYTES_PER_WORD;
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [POS_BITS-1:0] POS_LIMIT = POS_BITS'(1) << OFFSET_BITS;
    localparam logic [LEN_BITS-1:0] LEN_MAX   = LEN_BITS'(NEEDLE_MAX);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_NEEDLE_0  = 3'd0,
        CFG_NEEDLE_1  = 3'd1,
        CFG_NEEDLE_2  = 3'd2,
        CFG_NEEDLE_3  = 3'd3,
        CFG_LENGTH    = 3'd4,
        CFG_FOLD_CASE = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [NEEDLE_BYTES-1:0][7:0] needle;
        logic [LEN_BITS-1:0]          length;
        logic                         fold_case;
    } cfg_t;

    typedef struct packed {
        logic                   emit;
        logic                   found;
        logic [OFFSET_BITS-1:0] offset;
        logic                   too_long;
    } result_t;

    // Folds lower-case ASCII letters onto upper case when enabled.
    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
        logic [7:0] r;
        r = c;
        if (en && (c >= 8'h61) && (c <= 8'h7A)) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/substring_matcher_case_fold_top.sv =====
//  Channel  | Handshake          | Payload
//  ---------+--------------------+----------------------------------------
//  input    | s_valid / s_ready  | s_haystack_byte, s_last_byte
//  result   | m_valid / m_ready  | m_found, m_match_offset, m_too_long
//  config   | cfg_wr_en          | cfg_index, cfg_wdata (write only)
//
//  One haystack byte is taken per clock cycle while s_ready is high. A byte is
//  compared while it sits in the input register, and a result it causes is
//  loaded into the output register as the byte moves on, which drives m_valid.
//  The rate is set by the combinational window compare against the needle.
//  Reset is synchronous on aresetn and clears the search state and the needle.
//  A stall on m_ready holds the input register, and s_ready falls only when
//  both the input and output registers hold work that cannot move.

`default_nettype none

module substring_matcher_case_fold_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                cfg_wr_en,
    input  wire logic [scfc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [scfc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [7:0]                          s_haystack_byte,
    input  wire logic                                s_last_byte,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_found,
    output logic [scfc_pkg::OFFSET_BITS-1:0]         m_match_offset,
    output logic                                     m_too_long
);

    scfc_pkg::cfg_t    cfg;
    scfc_pkg::result_t res;

    // Input register: holds one haystack byte while it is compared.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Output register: holds one finished result until it is taken.
    logic                             out_valid_reg;
    logic                             out_found_reg;
    logic [scfc_pkg::OFFSET_BITS-1:0] out_offset_reg;
    logic                             out_long_reg;

    logic advance;

    // The byte in the input register moves on whenever the output register is
    // free or is being emptied in this cycle. Every byte is allowed to move only
    // then, which keeps results in order without looking at the compare result.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    scfc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    scfc_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .haystack_byte (in_byte_reg),
        .last_byte     (in_last_reg),
        .cfg           (cfg),
        .res           (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_haystack_byte;
            in_last_reg <= s_last_byte;
        end
    end

    // A new result may load in the same cycle the old one is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && res.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.emit) begin
            out_found_reg  <= res.found;
            out_offset_reg <= res.offset;
            out_long_reg   <= res.too_long;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_found        = out_found_reg;
    assign m_match_offset = out_offset_reg;
    assign m_too_long     = out_long_reg;

endmodule

`default_nettype wire

// ===== rtl/scfc_cfg.sv =====
`default_nettype none

module scfc_cfg (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [scfc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [scfc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    output scfc_pkg::cfg_t                           cfg
);

    logic [scfc_pkg::NEEDLE_WORDS-1:0][scfc_pkg::CFG_DATA_BITS-1:0] word_reg;
    logic [scfc_pkg::LEN_BITS-1:0]                                  length_reg;
    logic                                                           fold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg   <= '0;
            length_reg <= '0;
            fold_reg   <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                scfc_pkg::CFG_NEEDLE_0:  word_reg[0] <= cfg_wdata;
                scfc_pkg::CFG_NEEDLE_1:  word_reg[1] <= cfg_wdata;
                scfc_pkg::CFG_NEEDLE_2:  word_reg[2] <= cfg_wdata;
                scfc_pkg::CFG_NEEDLE_3:  word_reg[3] <= cfg_wdata;
                scfc_pkg::CFG_LENGTH:    length_reg <= cfg_wdata[scfc_pkg::LEN_BITS-1:0];
                scfc_pkg::CFG_FOLD_CASE: fold_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Byte k of the needle sits in word k/8, lowest byte first.
    always_comb begin
        for (int w = 0; w < scfc_pkg::NEEDLE_WORDS; w++) begin
            for (int k = 0; k < scfc_pkg::BYTES_PER_WORD; k++) begin
                cfg.needle[w*scfc_pkg::BYTES_PER_WORD + k] = word_reg[w][k*8 +: 8];
            end
        end
        cfg.length    = length_reg;
        cfg.fold_case = fold_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/scfc_core.sv =====
`default_nettype none

`include "substring_matcher_case_fold_top_assert.svh"

module scfc_core (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic [7:0] haystack_byte,
    input  wire logic       last_byte,
    input  wire scfc_pkg::cfg_t cfg,
    output scfc_pkg::result_t res
);

    logic [scfc_pkg::NEEDLE_MAX-1:0][7:0] window_reg, window_next, win_shift;
    logic [scfc_pkg::POS_BITS-1:0]        pos_reg, pos_next, pos_inc, start;
    logic                                 reported_reg, reported_next;
    logic [scfc_pkg::LEN_BITS-1:0]        len_eff;
    logic [scfc_pkg::NEEDLE_MAX-1:0]      lane_ok;
    logic                                 all_eq;
    logic                                 hit;

    assign len_eff = (cfg.length > scfc_pkg::LEN_MAX) ? scfc_pkg::LEN_MAX : cfg.length;
    assign pos_inc = pos_reg + scfc_pkg::POS_BITS'(1);

    // Window as it stands once the new byte is shifted in; newest at lane 0.
    always_comb begin
        win_shift[0] = haystack_byte;
        for (int i = 1; i < scfc_pkg::NEEDLE_MAX; i++) begin
            win_shift[i] = window_reg[i-1];
        end
    end

    // Lane i compares against needle byte len-1-i; lanes past the length pass.
    always_comb begin
        logic [scfc_pkg::LEN_BITS-1:0] idx;
        for (int i = 0; i < scfc_pkg::NEEDLE_MAX; i++) begin
            idx = len_eff - scfc_pkg::LEN_BITS'(i) - scfc_pkg::LEN_BITS'(1);
            lane_ok[i] = (scfc_pkg::LEN_BITS'(i) >= len_eff) ||
                (scfc_pkg::fold_byte(win_shift[i], cfg.fold_case) ==
                 scfc_pkg::fold_byte(cfg.needle[idx[scfc_pkg::NIDX_BITS-1:0]],
                                     cfg.fold_case));
        end
    end

    assign all_eq = &lane_ok;

    always_comb begin
        window_next   = window_reg;
        pos_next      = pos_reg;
        reported_next = reported_reg;
        hit           = 1'b0;
        start         = '0;
        res           = '0;
        if (step && !reported_reg) begin
            if (len_eff == '0) begin
                hit = 1'b1;
            end else if (pos_reg < scfc_pkg::POS_LIMIT) begin
                window_next = win_shift;
                pos_next    = pos_inc;
                if ((pos_inc >= scfc_pkg::POS_BITS'(len_eff)) && all_eq) begin
                    hit   = 1'b1;
                    start = pos_inc - scfc_pkg::POS_BITS'(len_eff);
                end
            end
            if (hit) begin
                reported_next = 1'b1;
            end
            res.emit     = hit || last_byte;
            res.found    = hit;
            res.offset   = start[scfc_pkg::OFFSET_BITS-1:0];
            res.too_long = !hit && (pos_next >= scfc_pkg::POS_LIMIT);
        end
        // The end of a haystack returns the search state to its idle values.
        if (step && last_byte) begin
            window_next   = '0;
            pos_next      = '0;
            reported_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg   <= '0;
            pos_reg      <= '0;
            reported_reg <= 1'b0;
        end else begin
            window_reg   <= window_next;
            pos_reg      <= pos_next;
            reported_reg <= reported_next;
        end
    end

    `SCFC_ASSERT(a_last_clears, aclk, aresetn,
        step && last_byte |=> (pos_reg == '0) && !reported_reg,
        "haystack state not cleared after last byte")
    `SCFC_ASSERT(a_pos_bound, aclk, aresetn,
        pos_reg <= scfc_pkg::POS_LIMIT,
        "byte position ran past its limit")
    `SCFC_ASSERT(a_single_report, aclk, aresetn,
        step && reported_reg |-> !res.emit,
        "second result for one haystack")
    `SCFC_ASSERT(a_found_not_long, aclk, aresetn,
        res.emit && res.found |-> !res.too_long,
        "found result flagged too long")

endmodule

`default_nettype wire
